### sv/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants of the adaptive step size controller
// Fixed-point formats, register and log slot codes, control/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package asc_pkg;

  localparam int FRAC_BITS   = 40;
  localparam int COUNT_WIDTH = 16;
  localparam int VAL_W       = 56;
  localparam int LOG_FRAC    = 24;
  localparam int SCL_FRAC    = 28;
  localparam int MANT_W      = 32;
  localparam int LOG_W       = 32;
  localparam int LOG_INT_W   = LOG_W - LOG_FRAC;
  localparam int ACC_W       = 48;
  localparam int DIFF_W      = 35;
  localparam int NUM_LOGS    = 7;
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;
  localparam int EXP_BIAS    = FRAC_BITS - (MANT_W - 1);
  localparam int EXP_SAT     = VAL_W - (MANT_W - 1);
  localparam int EXP_TOP_BIT = MANT_W - 2;

  localparam logic [VAL_W-1:0] ERR_RESET = 56'd1099511628;
  localparam logic [VAL_W-1:0] TOL_RESET = 56'd109951163;

  // log slots
  localparam logic [2:0] LOG_SAF   = 3'd0;
  localparam logic [2:0] LOG_STEP  = 3'd1;
  localparam logic [2:0] LOG_TOL   = 3'd2;
  localparam logic [2:0] LOG_ERR   = 3'd3;
  localparam logic [2:0] LOG_PREV  = 3'd4;
  localparam logic [2:0] LOG_PREV2 = 3'd5;
  localparam logic [2:0] LOG_LAST  = 3'd6;

  localparam logic [1:0] TERM_I = 2'd0;
  localparam logic [1:0] TERM_P = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  localparam logic [1:0] MODE_I   = 2'd0;
  localparam logic [1:0] MODE_PI  = 2'd1;
  localparam logic [1:0] MODE_PID = 2'd2;
  localparam logic [1:0] MODE_PC  = 2'd3;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_TOL    = 3'd1;
  localparam logic [2:0] REG_KP     = 3'd2;
  localparam logic [2:0] REG_KI     = 3'd3;
  localparam logic [2:0] REG_KD     = 3'd4;
  localparam logic [2:0] REG_SAFETY = 3'd5;
  localparam logic [2:0] REG_MAXS   = 3'd6;
  localparam logic [2:0] REG_MINS   = 3'd7;

  localparam logic OP_ERR  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [VAL_W-1:0]  tol;
    logic signed [31:0] k_p;
    logic signed [31:0] k_i;
    logic signed [31:0] k_d;
    logic [31:0]       safety;
    logic [31:0]       max_scale;
    logic [31:0]       min_scale;
  } cfg_t;

  typedef struct packed {
    logic       latch_in;
    logic       log_start;
    logic       log_store;
    logic [2:0] log_sel;
    logic       sum_init;
    logic       term_mul;
    logic       term_add;
    logic [1:0] term_sel;
    logic       exp_init;
    logic       exp_start;
    logic       exp_upd;
    logic [4:0] exp_bit;
    logic       scale_calc;
    logic       scale_zero;
    logic       clamp_mul;
    logic       clamp_add;
    logic       clamp_sel;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic zero_path;
    logic log_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### sv/asc_if.sv
// ----------------------------------------------------------------------------
// asc_in_if / asc_out_if: valid/ready channels of the step size controller
// Input carries op and value; output carries the step decision.
// ----------------------------------------------------------------------------
`default_nettype none

interface asc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [asc_pkg::VAL_W-1:0] value;
  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface asc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [asc_pkg::VAL_W-1:0]       new_step;
  logic [asc_pkg::COUNT_WIDTH-1:0] reject_count;
  modport source (output valid, output accepted, output new_step, output reject_count,
                  input ready);
  modport sink   (input valid, input accepted, input new_step, input reject_count,
                  output ready);
endinterface

`default_nettype wire

### sv/adaptive_step_size_controller.sv
// ----------------------------------------------------------------------------
// adaptive_step_size_controller: I / PI / PID / PC step length controller
// Proposes the next integrator step from error estimates in the log2 domain.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     op, value
//  out_ch    out  valid/ready     accepted, new_step, reject_count
//  apb       in   psel/penable    paddr[5:3] register, pwdata, prdata
//
// An error item runs seven logs and 31 exponent search probes, each 24 squarings
// (plus 6 normalize steps for a log) through the single log unit. A load item,
// or a zero step or safety, skips the logs and the search. The output register frees
// the input side; a stalled output holds the next result back. Reset is synchronous
// and restores the configuration, the history and the control state.
`default_nettype none

module adaptive_step_size_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  asc_in_if.sink                             in_ch,
  asc_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [asc_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [asc_pkg::CFG_DW-1:0]    pwdata,
  output logic [asc_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);

  asc_pkg::cfg_t cfg_r;
  asc_pkg::cmd_t cmd;
  asc_pkg::sts_t sts;
  logic [2:0]    ridx;
  logic          wr;

  assign ridx   = paddr[asc_pkg::CFG_AW-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= asc_pkg::MODE_PI;
      cfg_r.tol       <= asc_pkg::TOL_RESET;
      cfg_r.k_p       <= 32'sd0;
      cfg_r.k_i       <= 32'sd4194304;
      cfg_r.k_d       <= 32'sd0;
      cfg_r.safety    <= 32'd241591910;
      cfg_r.max_scale <= 32'd536870912;
      cfg_r.min_scale <= 32'd53687091;
    end else if (wr) begin
      case (ridx)
        asc_pkg::REG_MODE:   cfg_r.mode      <= pwdata[1:0];
        asc_pkg::REG_TOL:    cfg_r.tol       <= pwdata[asc_pkg::VAL_W-1:0];
        asc_pkg::REG_KP:     cfg_r.k_p       <= pwdata[31:0];
        asc_pkg::REG_KI:     cfg_r.k_i       <= pwdata[31:0];
        asc_pkg::REG_KD:     cfg_r.k_d       <= pwdata[31:0];
        asc_pkg::REG_SAFETY: cfg_r.safety    <= pwdata[31:0];
        asc_pkg::REG_MAXS:   cfg_r.max_scale <= pwdata[31:0];
        asc_pkg::REG_MINS:   cfg_r.min_scale <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      asc_pkg::REG_MODE:   prdata = 64'(cfg_r.mode);
      asc_pkg::REG_TOL:    prdata = 64'(cfg_r.tol);
      asc_pkg::REG_KP:     prdata = 64'(unsigned'(cfg_r.k_p));
      asc_pkg::REG_KI:     prdata = 64'(unsigned'(cfg_r.k_i));
      asc_pkg::REG_KD:     prdata = 64'(unsigned'(cfg_r.k_d));
      asc_pkg::REG_SAFETY: prdata = 64'(cfg_r.safety);
      asc_pkg::REG_MAXS:   prdata = 64'(cfg_r.max_scale);
      asc_pkg::REG_MINS:   prdata = 64'(cfg_r.min_scale);
      default:             prdata = '0;
    endcase
  end

  asc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  asc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_ch.op),
    .in_value         (in_ch.value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_accepted     (out_ch.accepted),
    .out_new_step     (out_ch.new_step),
    .out_reject_count (out_ch.reject_count)
  );

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in work");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("commit did not fill the output register");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.log_start, cmd.exp_start, cmd.term_mul, cmd.clamp_mul, cmd.commit}))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

### sv/asc_log_unit.sv
// ----------------------------------------------------------------------------
// asc_log_unit: iterative log2 fraction unit
// Normalizes in six shift steps (log start only), then 24 truncated squarings, one bit each.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_log_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          norm,
  input  wire logic [63:0]                   x,
  input  wire logic [asc_pkg::MANT_W-1:0]    mant,
  output logic                               done,
  output logic [asc_pkg::LOG_FRAC-1:0]       frac,
  output logic [5:0]                         msb
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQ   = 3'b100
  } lstate_t;

  lstate_t                        st_r, st_nxt;
  logic [4:0]                     cnt_r;
  logic [63:0]                    x_r;
  logic [5:0]                     p_r;
  logic [asc_pkg::MANT_W-1:0]     m_r;
  logic [asc_pkg::LOG_FRAC-1:0]   r_r;
  logic                           done_r;

  logic [5:0]                     sh;
  logic                           top_zero;
  logic [63:0]                    x_sh;
  logic [63:0]                    prod;
  logic [asc_pkg::MANT_W:0]       sq;

  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin sh = 6'd32; top_zero = (x_r[63:32] == '0); end
      3'd1:    begin sh = 6'd16; top_zero = (x_r[63:48] == '0); end
      3'd2:    begin sh = 6'd8;  top_zero = (x_r[63:56] == '0); end
      3'd3:    begin sh = 6'd4;  top_zero = (x_r[63:60] == '0); end
      3'd4:    begin sh = 6'd2;  top_zero = (x_r[63:62] == '0); end
      default: begin sh = 6'd1;  top_zero = ~x_r[63]; end
    endcase
    x_sh = top_zero ? (x_r << sh) : x_r;
    prod = 64'(m_r) * 64'(m_r);
    sq   = prod[63:asc_pkg::MANT_W-1];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE:  if (start) st_nxt = norm ? L_NORM : L_SQ;
      L_NORM:  if (cnt_r == 5'd5) st_nxt = L_SQ;
      L_SQ:    if (cnt_r == 5'(asc_pkg::LOG_FRAC - 1)) st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      case (st_r)
        L_IDLE:  cnt_r <= '0;
        L_NORM:  cnt_r <= (cnt_r == 5'd5) ? '0 : cnt_r + 5'd1;
        L_SQ: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(asc_pkg::LOG_FRAC - 1)) done_r <= 1'b1;
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      L_IDLE: begin
        if (start) begin
          x_r <= (x == '0) ? 64'd1 : x;
          p_r <= 6'd63;
          m_r <= mant;
          r_r <= '0;
        end
      end
      L_NORM: begin
        x_r <= x_sh;
        if (top_zero) p_r <= p_r - sh;
        if (cnt_r == 5'd5) m_r <= x_sh[63:64-asc_pkg::MANT_W];
      end
      L_SQ: begin
        // value >= 2 gives a one bit and is halved
        if (sq[asc_pkg::MANT_W]) begin
          m_r <= sq[asc_pkg::MANT_W:1];
          r_r <= {r_r[asc_pkg::LOG_FRAC-2:0], 1'b1};
        end else begin
          m_r <= sq[asc_pkg::MANT_W-1:0];
          r_r <= {r_r[asc_pkg::LOG_FRAC-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign frac = r_r;
  assign msb  = p_r;

endmodule

`default_nettype wire

### sv/asc_datapath.sv
// ----------------------------------------------------------------------------
// asc_datapath: registers and arithmetic of the step size controller
// Log slots, term products, exponent search, clamp products, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire asc_pkg::cfg_t                     cfg,
  input  wire asc_pkg::cmd_t                     cmd,
  output asc_pkg::sts_t                          sts,
  input  wire logic                              in_op,
  input  wire logic [asc_pkg::VAL_W-1:0]         in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_accepted,
  output logic [asc_pkg::VAL_W-1:0]              out_new_step,
  output logic [asc_pkg::COUNT_WIDTH-1:0]        out_reject_count
);

  localparam int VW = asc_pkg::VAL_W;
  localparam int AW = asc_pkg::ACC_W;
  localparam int DW = asc_pkg::DIFF_W;
  localparam int SF = asc_pkg::SCL_FRAC;
  localparam int PW = VW - SF + 32;

  // item and history
  logic                               op_r;
  logic [VW-1:0]                      e_r;
  logic [VW-1:0]                      err_prev_r, err_prev2_r, step_r, last_r;
  logic [asc_pkg::COUNT_WIDTH-1:0]    rej_r, rej_nxt;

  logic signed [asc_pkg::LOG_W-1:0]   lg_r [asc_pkg::NUM_LOGS];
  logic signed [AW-1:0]               acc_r;
  logic signed [DW+31:0]              tprod_r;
  logic [asc_pkg::MANT_W-1:0]         m_r;
  logic [VW-1:0]                      scale_r, lo_r, hi_r;
  logic [PW-1:0]                      pa_r, pb_r;

  logic                               out_valid_r, out_acc_r;
  logic [VW-1:0]                      out_step_r;
  logic [asc_pkg::COUNT_WIDTH-1:0]    out_rej_r;

  // log unit hookup
  logic [63:0]                        lx;
  logic [asc_pkg::MANT_W-1:0]         lmant;
  logic                               l_done;
  logic [asc_pkg::LOG_FRAC-1:0]       l_frac;
  logic [5:0]                         l_msb;
  logic signed [asc_pkg::LOG_INT_W-1:0] l_int;
  logic signed [asc_pkg::LOG_INT_W-1:0] l_fb;

  logic signed [DW-1:0]               d_tol, d_prev, d_prev2, d_err, dsel;
  logic signed [31:0]                 ksel;
  logic                               term_en;
  logic signed [AW-1:0]               sum0;

  logic signed [23:0]                 n_exp;
  logic signed [24:0]                 sh_s, sh_neg;
  logic [63:0]                        m_l, m_rt;
  logic [VW-1:0]                      scale_v;

  logic [31:0]                        cb;
  logic [PW:0]                        csum;
  logic [VW-1:0]                      csat;
  logic [VW-1:0]                      nstep, nlo;
  logic                               acc_ok;

  always_comb begin
    case (cmd.log_sel)
      asc_pkg::LOG_SAF:   lx = 64'(cfg.safety);
      asc_pkg::LOG_STEP:  lx = 64'(step_r);
      asc_pkg::LOG_TOL:   lx = 64'(cfg.tol);
      asc_pkg::LOG_ERR:   lx = 64'(e_r);
      asc_pkg::LOG_PREV:  lx = 64'(err_prev_r);
      asc_pkg::LOG_PREV2: lx = 64'(err_prev2_r);
      asc_pkg::LOG_LAST:  lx = 64'(last_r);
      default:            lx = '0;
    endcase
    l_fb  = (cmd.log_sel == asc_pkg::LOG_SAF) ? asc_pkg::LOG_INT_W'(SF)
                                              : asc_pkg::LOG_INT_W'(asc_pkg::FRAC_BITS);
    l_int = $signed({2'b00, l_msb}) - l_fb;
    lmant = m_r | (asc_pkg::MANT_W'(1) << cmd.exp_bit);
  end

  asc_log_unit u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.log_start | cmd.exp_start),
    .norm  (cmd.log_start),
    .x     (lx),
    .mant  (lmant),
    .done  (l_done),
    .frac  (l_frac),
    .msb   (l_msb)
  );

  // exponent terms
  always_comb begin
    d_tol   = DW'(lg_r[asc_pkg::LOG_TOL]);
    d_err   = DW'(lg_r[asc_pkg::LOG_ERR]);
    d_prev  = DW'(lg_r[asc_pkg::LOG_PREV]);
    d_prev2 = DW'(lg_r[asc_pkg::LOG_PREV2]);
    case (cmd.term_sel)
      asc_pkg::TERM_I: begin
        dsel = d_tol - d_err;  ksel = cfg.k_i; term_en = 1'b1;
      end
      asc_pkg::TERM_P: begin
        dsel = d_prev - d_err; ksel = cfg.k_p; term_en = (cfg.mode != asc_pkg::MODE_I);
      end
      asc_pkg::TERM_D: begin
        dsel = (d_prev <<< 1) - d_err - d_prev2; ksel = cfg.k_d;
        term_en = (cfg.mode == asc_pkg::MODE_PID);
      end
      default: begin
        dsel = '0; ksel = '0; term_en = 1'b0;
      end
    endcase
    sum0 = AW'(lg_r[asc_pkg::LOG_SAF]) + AW'(lg_r[asc_pkg::LOG_STEP]);
    if (cfg.mode == asc_pkg::MODE_PC)
      sum0 = sum0 + AW'(lg_r[asc_pkg::LOG_STEP]) - AW'(lg_r[asc_pkg::LOG_LAST]);
  end

  // 2^x scaling of the found mantissa
  always_comb begin
    n_exp  = acc_r[AW-1:asc_pkg::LOG_FRAC];
    sh_s   = 25'(n_exp) + 25'(asc_pkg::EXP_BIAS);
    sh_neg = -sh_s;
    m_l    = 64'(m_r) << sh_s[4:0];
    m_rt   = 64'(m_r) >> sh_neg[5:0];
    if (sh_s >= 25'(asc_pkg::EXP_SAT))  scale_v = '1;
    else if (sh_s >= 25'sd0)            scale_v = m_l[VW-1:0];
    else if (sh_s <= -25'sd64)          scale_v = '0;
    else                                scale_v = m_rt[VW-1:0];
  end

  // clamp bound product, sum and saturation
  always_comb begin
    cb   = cmd.clamp_sel ? cfg.max_scale : cfg.min_scale;
    csum = (PW+1)'(pa_r) + (PW+1)'(pb_r[PW-1:SF]);
    csat = (csum[PW:VW] != '0) ? '1 : csum[VW-1:0];
    nlo   = (scale_r < lo_r) ? lo_r : scale_r;
    nstep = (nlo > hi_r) ? hi_r : nlo;
    acc_ok  = (e_r <= cfg.tol);
    rej_nxt = (rej_r != '1) ? rej_r + 1'b1 : rej_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= in_op;
      e_r  <= in_value;
    end
    if (cmd.log_store && (cmd.log_sel < 3'(asc_pkg::NUM_LOGS)))
      lg_r[cmd.log_sel] <= {l_int, l_frac};
    if (cmd.sum_init) acc_r <= sum0;
    if (cmd.term_mul) tprod_r <= (DW+32)'(ksel) * (DW+32)'(dsel);
    if (cmd.term_add && term_en)
      acc_r <= acc_r + AW'(tprod_r >>> asc_pkg::LOG_FRAC);
    if (cmd.exp_init) m_r <= asc_pkg::MANT_W'(1) << (asc_pkg::MANT_W - 1);
    if (cmd.exp_upd && (l_frac <= acc_r[asc_pkg::LOG_FRAC-1:0])) m_r <= lmant;
    if (cmd.scale_calc) scale_r <= scale_v;
    if (cmd.scale_zero) scale_r <= '0;
    if (cmd.clamp_mul) begin
      pa_r <= PW'(step_r[VW-1:SF]) * PW'(cb);
      pb_r <= PW'(step_r[SF-1:0]) * PW'(cb);
    end
    if (cmd.clamp_add) begin
      if (cmd.clamp_sel) hi_r <= csat;
      else               lo_r <= csat;
    end
    if (cmd.commit) begin
      out_acc_r <= (op_r == asc_pkg::OP_LOAD) ? 1'b1 : acc_ok;
      out_step_r <= (op_r == asc_pkg::OP_LOAD) ? e_r : nstep;
      out_rej_r <= (op_r == asc_pkg::OP_LOAD || acc_ok) ? rej_r : rej_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_prev_r  <= asc_pkg::ERR_RESET;
      err_prev2_r <= asc_pkg::ERR_RESET;
      step_r      <= '0;
      last_r      <= '0;
      rej_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (op_r == asc_pkg::OP_LOAD) begin
          step_r <= e_r;
          last_r <= e_r;
        end else begin
          step_r <= nstep;
          if (acc_ok) begin
            err_prev2_r <= err_prev_r;
            err_prev_r  <= e_r;
            last_r      <= nstep;
          end else begin
            rej_r <= rej_nxt;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.in_op     = in_op;
  assign sts.zero_path = (step_r == '0) || (cfg.safety == '0);
  assign sts.log_done  = l_done;
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_new_step     = out_step_r;
  assign out_reject_count = out_rej_r;

endmodule

`default_nettype wire

### sv/asc_ctrl.sv
// ----------------------------------------------------------------------------
// asc_ctrl: sequencer of the step size controller
// Walks logs, terms, exponent search, clamp and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire asc_pkg::sts_t  sts,
  output asc_pkg::cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_LOG_GO    = 11'b00000000010,
    S_LOG_WAIT  = 11'b00000000100,
    S_SUM       = 11'b00000001000,
    S_TERM_MUL  = 11'b00000010000,
    S_TERM_ADD  = 11'b00000100000,
    S_EXP_GO    = 11'b00001000000,
    S_EXP_WAIT  = 11'b00010000000,
    S_EXP_FIN   = 11'b00100000000,
    S_CLAMP_MUL = 11'b01000000000,
    S_CLAMP_ADD = 11'b10000000000
  } state_t;

  // commit waits in S_IDLE with fin_r set after S_CLAMP_ADD: a new input
  // is only taken once the result is in the output register.
  state_t      st_r, st_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  li_r, li_nxt;
  logic [1:0]  ti_r, ti_nxt;
  logic [4:0]  bi_r, bi_nxt;
  logic        ci_r, ci_nxt;
  logic        take;

  assign take = in_valid && in_ready;

  always_comb begin
    st_nxt  = st_r;
    fin_nxt = fin_r;
    li_nxt  = li_r;
    ti_nxt  = ti_r;
    bi_nxt  = bi_r;
    ci_nxt  = ci_r;
    cmd     = '0;
    cmd.log_sel   = li_r;
    cmd.term_sel  = ti_r;
    cmd.exp_bit   = bi_r;
    cmd.clamp_sel = ci_r;
    in_ready = (st_r == S_IDLE) && !fin_r;
    case (st_r)
      S_IDLE: begin
        if (fin_r) begin
          // result ready, wait for a free output register
          if (!sts.out_busy) begin
            cmd.commit = 1'b1;
            fin_nxt    = 1'b0;
          end
        end else if (take) begin
          cmd.latch_in = 1'b1;
          if (sts.in_op == asc_pkg::OP_LOAD) begin
            fin_nxt = 1'b1;
          end else if (sts.zero_path) begin
            cmd.scale_zero = 1'b1;
            ci_nxt = 1'b0;
            st_nxt = S_CLAMP_MUL;
          end else begin
            li_nxt = asc_pkg::LOG_SAF;
            st_nxt = S_LOG_GO;
          end
        end
      end
      S_LOG_GO: begin
        cmd.log_start = 1'b1;
        st_nxt = S_LOG_WAIT;
      end
      S_LOG_WAIT: begin
        if (sts.log_done) begin
          cmd.log_store = 1'b1;
          if (li_r == asc_pkg::LOG_LAST) begin
            st_nxt = S_SUM;
          end else begin
            li_nxt = li_r + 3'd1;
            st_nxt = S_LOG_GO;
          end
        end
      end
      S_SUM: begin
        cmd.sum_init = 1'b1;
        ti_nxt = asc_pkg::TERM_I;
        st_nxt = S_TERM_MUL;
      end
      S_TERM_MUL: begin
        cmd.term_mul = 1'b1;
        st_nxt = S_TERM_ADD;
      end
      S_TERM_ADD: begin
        cmd.term_add = 1'b1;
        if (ti_r == asc_pkg::TERM_D) begin
          cmd.exp_init = 1'b1;
          bi_nxt = 5'(asc_pkg::EXP_TOP_BIT);
          st_nxt = S_EXP_GO;
        end else begin
          ti_nxt = ti_r + 2'd1;
          st_nxt = S_TERM_MUL;
        end
      end
      S_EXP_GO: begin
        cmd.exp_start = 1'b1;
        st_nxt = S_EXP_WAIT;
      end
      S_EXP_WAIT: begin
        if (sts.log_done) begin
          cmd.exp_upd = 1'b1;
          if (bi_r == '0) begin
            st_nxt = S_EXP_FIN;
          end else begin
            bi_nxt = bi_r - 5'd1;
            st_nxt = S_EXP_GO;
          end
        end
      end
      S_EXP_FIN: begin
        cmd.scale_calc = 1'b1;
        ci_nxt = 1'b0;
        st_nxt = S_CLAMP_MUL;
      end
      S_CLAMP_MUL: begin
        cmd.clamp_mul = 1'b1;
        st_nxt = S_CLAMP_ADD;
      end
      S_CLAMP_ADD: begin
        cmd.clamp_add = 1'b1;
        if (ci_r) begin
          fin_nxt = 1'b1;
          st_nxt  = S_IDLE;
        end else begin
          ci_nxt = 1'b1;
          st_nxt = S_CLAMP_MUL;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      fin_r <= 1'b0;
      li_r  <= '0;
      ti_r  <= '0;
      bi_r  <= '0;
      ci_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      fin_r <= fin_nxt;
      li_r  <= li_nxt;
      ti_r  <= ti_nxt;
      bi_r  <= bi_nxt;
      ci_r  <= ci_nxt;
    end
  end

endmodule

`default_nettype wire

### tb/adaptive_step_size_controller_test.sv
// ----------------------------------------------------------------------------
// adaptive_step_size_controller_test: self-checking bench of the step controller
// Drives error and load items with random gaps and output stalls, writes the
// registers over APB between phases, and checks each result against a
// fixed-point predictor of the I / PI / PID / PC step law.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_step_size_controller_test;
  import asc_pkg::*;

  localparam int                CLK_HALF   = 4;
  localparam int                STALL_MAX  = 20000;
  localparam int                DRAIN_WAIT = 1200;
  localparam logic [VAL_W-1:0]  VAL_MAX    = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0]  ONE_Q40    = 56'd1 << FRAC_BITS;
  localparam logic [31:0]       ONE_Q28    = 32'd1 << SCL_FRAC;

  typedef struct {
    bit                   accepted;
    bit [VAL_W-1:0]       new_step;
    bit [COUNT_WIDTH-1:0] reject_count;
  } step_result_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  asc_in_if  in_ch ();
  asc_out_if out_ch ();

  adaptive_step_size_controller i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of registers and history
  bit [1:0]             cfg_mode;
  bit [VAL_W-1:0]       cfg_tol;
  bit [31:0]            cfg_kp, cfg_ki, cfg_kd;
  bit [31:0]            cfg_safety, cfg_max_scale, cfg_min_scale;
  bit [VAL_W-1:0]       hist_err1, hist_err0, cur_step, last_step;
  bit [COUNT_WIDTH-1:0] reject_total;

  step_result_t pending_steps[$];
  int  fail_count;
  int  stall_cycles;
  bit  send_gaps;
  bit  rx_steady;
  bit  hold_req;
  int  hold_len;
  int  hold_left;

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic bit [63:0] log_frac_bits(bit [63:0] m);
    bit [63:0] r;
    r = 0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      r = r << 1;
      if ((m >> 32) != 0) begin
        m = m >> 1;
        r = r | 64'd1;
      end
    end
    return r;
  endfunction

  function automatic longint log2_fixed(bit [63:0] x, int fb);
    int        p;
    bit [63:0] m;
    if (x == 0) x = 1;  // zero counts as one LSB
    p = 63;
    while (!x[p]) p--;
    m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
    return longint'(p - fb) * (longint'(1) << LOG_FRAC) + longint'(log_frac_bits(m));
  endfunction

  function automatic bit [63:0] pow2_fixed(longint t);
    longint    n;
    longint    s;
    bit [63:0] f;
    bit [63:0] m;
    bit [63:0] c;
    n = t >>> LOG_FRAC;
    f = t & 64'hFF_FFFF;
    m = 64'h8000_0000;
    for (int b = 30; b >= 0; b--) begin
      c = m | (64'd1 << b);
      if (log_frac_bits(c) <= f) m = c;
    end
    s = n + FRAC_BITS - 31;
    if (s >= VAL_W - 31) return 64'(VAL_MAX);
    if (s >= 0) return m << s;
    if (s <= -64) return 0;
    return m >> (-s);
  endfunction

  // both partial products fit in 64 bits; the sum saturates at VAL_MAX
  function automatic bit [63:0] scale_step(bit [63:0] a, bit [63:0] b);
    bit [63:0] r;
    r = (a >> SCL_FRAC) * b + (((a & 64'hFFF_FFFF) * b) >> SCL_FRAC);
    return (r > 64'(VAL_MAX)) ? 64'(VAL_MAX) : r;
  endfunction

  function automatic longint gain_term(bit [31:0] k, longint d);
    longint kk;
    kk = longint'($signed(k));
    return (kk * d) >>> LOG_FRAC;
  endfunction

  function automatic step_result_t predict_step(bit op, bit [VAL_W-1:0] v);
    step_result_t r;
    bit [63:0]    scale;
    bit [63:0]    lo;
    bit [63:0]    hi;
    bit [63:0]    nstep;
    longint       le, l1, l0, lt, ls, acc_sum;
    scale = 0;
    if (op == OP_LOAD) begin
      cur_step  = v;
      last_step = v;
      r.accepted = 1'b1;
      r.new_step = v;
      r.reject_count = reject_total;
      return r;
    end
    if (cur_step != 0 && cfg_safety != 0) begin
      le = log2_fixed(64'(v), FRAC_BITS);
      l1 = log2_fixed(64'(hist_err1), FRAC_BITS);
      l0 = log2_fixed(64'(hist_err0), FRAC_BITS);
      lt = log2_fixed(64'(cfg_tol), FRAC_BITS);
      ls = log2_fixed(64'(cur_step), FRAC_BITS);
      acc_sum = log2_fixed(64'(cfg_safety), SCL_FRAC) + ls + gain_term(cfg_ki, lt - le);
      if (cfg_mode != MODE_I) acc_sum += gain_term(cfg_kp, l1 - le);
      if (cfg_mode == MODE_PID) acc_sum += gain_term(cfg_kd, 2 * l1 - le - l0);
      if (cfg_mode == MODE_PC) acc_sum += ls - log2_fixed(64'(last_step), FRAC_BITS);
      scale = pow2_fixed(acc_sum);
    end
    lo = scale_step(64'(cur_step), 64'(cfg_min_scale));
    hi = scale_step(64'(cur_step), 64'(cfg_max_scale));
    nstep = (scale < lo) ? lo : scale;
    if (nstep > hi) nstep = hi;  // upper bound wins
    r.accepted = (v <= cfg_tol);
    if (r.accepted) begin
      hist_err0 = hist_err1;
      hist_err1 = v;
      last_step = nstep[VAL_W-1:0];
    end else if (reject_total != {COUNT_WIDTH{1'b1}}) begin
      reject_total++;
    end
    cur_step = nstep[VAL_W-1:0];
    r.new_step = nstep[VAL_W-1:0];
    r.reject_count = reject_total;
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(bit op, bit [VAL_W-1:0] v);
    @(negedge clk);
    while (send_gaps && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    pending_steps.push_back(predict_step(op, v));
  endtask

  task automatic send_error(bit [VAL_W-1:0] v);
    send_item(OP_ERR, v);
  endtask

  task automatic send_load(bit [VAL_W-1:0] v);
    send_item(OP_LOAD, v);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MODE:   cfg_mode      = data[1:0];
      REG_TOL:    cfg_tol       = data[VAL_W-1:0];
      REG_KP:     cfg_kp        = data[31:0];
      REG_KI:     cfg_ki        = data[31:0];
      REG_KD:     cfg_kd        = data[31:0];
      REG_SAFETY: cfg_safety    = data[31:0];
      REG_MAXS:   cfg_max_scale = data[31:0];
      default:    cfg_min_scale = data[31:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all_regs(bit [1:0] m, bit [VAL_W-1:0] t, bit [31:0] kp,
                                bit [31:0] ki, bit [31:0] kd, bit [31:0] saf,
                                bit [31:0] mx, bit [31:0] mn);
    drain_results();
    write_reg(REG_MODE, 64'(m));
    write_reg(REG_TOL, 64'(t));
    write_reg(REG_KP, 64'(kp));
    write_reg(REG_KI, 64'(ki));
    write_reg(REG_KD, 64'(kd));
    write_reg(REG_SAFETY, 64'(saf));
    write_reg(REG_MAXS, 64'(mx));
    write_reg(REG_MINS, 64'(mn));
  endtask

  function automatic bit [VAL_W-1:0] rand_value();
    return {$urandom, $urandom} & VAL_MAX;
  endfunction

  // mostly modest exponents, some fully random
  function automatic bit [31:0] rand_gain();
    bit [31:0] k;
    if ($urandom_range(9) == 0) return $urandom;
    k = $urandom_range(0, 32'h0180_0000);
    return $urandom_range(1) ? -k : k;
  endfunction

  // error near the tolerance, shifted a few octaves either way
  function automatic bit [VAL_W-1:0] near_tol_error();
    bit [VAL_W-1:0] e;
    int             sh;
    sh = $urandom_range(0, 6);
    e = $urandom_range(1) ? (cfg_tol >> sh) : (cfg_tol << sh);
    return e ^ ($urandom & 32'h0000_FFFF);
  endfunction

  // ---------------- result checker ----------------
  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    step_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_steps.size() == 0) begin
        report("unexpected item", out_ch.new_step, 0);
      end else begin
        want = pending_steps.pop_front();
        if (out_ch.accepted !== want.accepted)
          report("accepted", out_ch.accepted, want.accepted);
        if (out_ch.new_step !== want.new_step)
          report("new_step", out_ch.new_step, want.new_step);
        if (out_ch.reject_count !== want.reject_count)
          report("reject_count", out_ch.reject_count, want.reject_count);
      end
    end
  end

  // receiver: random stalls, optional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rx_steady || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("FAIL adaptive_step_size_controller");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------- tests ----------------
  task automatic test_before_load();
    // step still zero: proposal and bounds are zero
    send_error(56'd0);
    send_error(VAL_MAX);
  endtask

  task automatic test_load_extremes();
    send_load(VAL_MAX);
    send_load(56'd0);
    send_load(ONE_Q40 >> 10);
  endtask

  task automatic test_each_mode();
    for (int m = 0; m < 4; m++) begin
      write_all_regs(m[1:0], TOL_RESET, 32'hFFF0_0000, 32'h0040_0000, 32'h0020_0000,
                     32'd241591910, 32'd536870912, 32'd53687091);
      send_error(TOL_RESET >> 2);
      send_error(TOL_RESET << 3);
      send_error(TOL_RESET);
    end
  endtask

  task automatic test_special_values();
    send_error(56'd0);              // zero error
    send_error(TOL_RESET + 56'd1);  // just above tolerance
    send_error(VAL_MAX);
    write_all_regs(MODE_PID, 56'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'd0, 32'hFFFF_FFFF, 32'd0);
    send_error(56'd0);              // zero tolerance, zero safety
    send_load(ONE_Q40);
    write_all_regs(MODE_PC, VAL_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_error(VAL_MAX);            // min scale above max scale
    send_error(56'd1);
  endtask

  task automatic random_phase(int items, bit extreme);
    bit [VAL_W-1:0] t;
    if (extreme) begin
      write_all_regs(MODE_PID, 56'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    end else begin
      t = (56'd1 << $urandom_range(16, 44)) | ($urandom & 32'h00FF_FFFF);
      write_all_regs($urandom_range(3), t, rand_gain(), rand_gain(), rand_gain(),
                     ($urandom_range(7) == 0) ? $urandom : ONE_Q28 - $urandom_range(0, 1 << 26),
                     ($urandom_range(7) == 0) ? $urandom : $urandom_range(ONE_Q28, 32'h3FFF_FFFF),
                     ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, ONE_Q28));
    end
    send_load((ONE_Q40 >> $urandom_range(0, 24)) ^ ($urandom & 32'hFFFF));
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(19))
        0:       send_load(rand_value());
        1, 2:    send_error(rand_value());
        3:       send_load((ONE_Q40 >> $urandom_range(0, 30)) | $urandom_range(0, 255));
        default: send_error(near_tol_error());
      endcase
    end
  endtask

  task automatic test_backpressure();
    write_all_regs(MODE_PI, TOL_RESET, 32'hFFF0_0000, 32'h0040_0000, 32'd0,
                   32'd241591910, 32'd536870912, 32'd53687091);
    send_load(ONE_Q40 >> 8);
    hold_len = 3000;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_error(near_tol_error());
    for (int i = 0; i < 30; i++) send_load(rand_value());
    drain_results();  // sender waits for every result
    send_gaps = 1'b0;
    rx_steady = 1'b1;
    for (int i = 0; i < 40; i++) send_error(near_tol_error());
    send_gaps = 1'b1;
    rx_steady = 1'b0;
  endtask

  task automatic test_reject_burst();
    // zero step keeps the error path short
    write_all_regs(MODE_I, 56'd0, 32'd0, 32'h0040_0000, 32'd0,
                   32'd241591910, 32'd536870912, 32'd53687091);
    send_load(56'd0);
    send_gaps = 1'b0;
    rx_steady = 1'b1;
    for (int i = 0; i < 20; i++) send_error(56'd1 + $urandom_range(0, 3));
    send_load(ONE_Q40);
    send_error(56'd0);
    send_error(56'd5);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_ERR;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    fail_count   = 0;
    stall_cycles = 0;
    send_gaps    = 1'b1;
    rx_steady    = 1'b0;
    hold_req     = 1'b0;
    hold_len     = 0;
    hold_left    = 0;

    cfg_mode      = MODE_PI;
    cfg_tol       = TOL_RESET;
    cfg_kp        = 32'd0;
    cfg_ki        = 32'd4194304;
    cfg_kd        = 32'd0;
    cfg_safety    = 32'd241591910;
    cfg_max_scale = 32'd536870912;
    cfg_min_scale = 32'd53687091;
    hist_err1     = ERR_RESET;
    hist_err0     = ERR_RESET;
    cur_step      = '0;
    last_step     = '0;
    reject_total  = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_before_load();
    test_load_extremes();
    test_special_values();
    test_each_mode();
    random_phase(60, 1'b1);
    for (int p = 0; p < 10; p++) random_phase(140, 1'b0);
    test_backpressure();
    test_reject_burst();

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS adaptive_step_size_controller");
    end else begin
      $display("FAIL adaptive_step_size_controller");
    end
    $finish;
  end

endmodule

`default_nettype wire
